@@ rtl/core/kste_pkg.sv @@
// Shared types and constants for the keysym to terminal escape encoder.
package kste_pkg;

    // Longest byte sequence for one key
    localparam int unsigned SEQ_MAX = 7;
    localparam int unsigned LEN_W   = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SHIFT_MASK   = 2'd0;
    localparam logic [1:0] CFG_ALT_MASK     = 2'd1;
    localparam logic [1:0] CFG_CONTROL_MASK = 2'd2;

    typedef enum logic [1:0] {
        STATUS_BYTE   = 2'd0,
        STATUS_NONE   = 2'd1,
        STATUS_NOCONV = 2'd2
    } status_t;

    // Input transaction
    typedef struct packed {
        logic [28:0] key_symbol;
        logic [7:0]  modifier_state;
        logic        cursor_app_mode;
        logic        newline_mode;
    } key_item_t;

    // Output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        status_t    status;
    } key_result_t;

    // Modifier masks
    typedef struct packed {
        logic [7:0] shift_mask;
        logic [7:0] alt_mask;
        logic [7:0] control_mask;
    } kste_cfg_t;

    // Whole encoded sequence for one key
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]        len;
        status_t                 status;
    } kste_seq_t;

endpackage

@@ rtl/core/kste_encoder.sv @@
// Combinational encoder: one registered key item to its full byte sequence.
module kste_encoder
    import kste_pkg::*;
(
    input  key_item_t item,
    input  kste_cfg_t cfg,
    output kste_seq_t seq
);

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SS3    = 8'h4F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [28:0] KS_BACKSPACE = 29'h0FF08;
    localparam logic [28:0] KS_TAB       = 29'h0FF09;
    localparam logic [28:0] KS_LINEFEED  = 29'h0FF0A;
    localparam logic [28:0] KS_CLEAR     = 29'h0FF0B;
    localparam logic [28:0] KS_RETURN    = 29'h0FF0D;
    localparam logic [28:0] KS_PAUSE     = 29'h0FF13;
    localparam logic [28:0] KS_SCROLL    = 29'h0FF14;
    localparam logic [28:0] KS_SYSREQ    = 29'h0FF15;
    localparam logic [28:0] KS_ESCAPE    = 29'h0FF1B;
    localparam logic [28:0] KS_HOME      = 29'h0FF50;
    localparam logic [28:0] KS_LEFT      = 29'h0FF51;
    localparam logic [28:0] KS_UP        = 29'h0FF52;
    localparam logic [28:0] KS_RIGHT     = 29'h0FF53;
    localparam logic [28:0] KS_DOWN      = 29'h0FF54;
    localparam logic [28:0] KS_PRIOR     = 29'h0FF55;
    localparam logic [28:0] KS_NEXT      = 29'h0FF56;
    localparam logic [28:0] KS_END       = 29'h0FF57;
    localparam logic [28:0] KS_INSERT    = 29'h0FF63;
    localparam logic [28:0] KS_DELETE    = 29'h0FFFF;
    localparam logic [28:0] KS_KP_SPACE  = 29'h0FF80;
    localparam logic [28:0] KS_KP_TAB    = 29'h0FF89;
    localparam logic [28:0] KS_KP_ENTER  = 29'h0FF8D;
    localparam logic [28:0] KS_KP_LEFT   = 29'h0FF96;
    localparam logic [28:0] KS_KP_UP     = 29'h0FF97;
    localparam logic [28:0] KS_KP_RIGHT  = 29'h0FF98;
    localparam logic [28:0] KS_KP_DOWN   = 29'h0FF99;
    localparam logic [28:0] KS_KP_EQUAL  = 29'h0FFBD;
    localparam logic [28:0] KS_KP_MUL    = 29'h0FFAA;
    localparam logic [28:0] KS_KP_ADD    = 29'h0FFAB;
    localparam logic [28:0] KS_KP_SEP    = 29'h0FFAC;
    localparam logic [28:0] KS_KP_SUB    = 29'h0FFAD;
    localparam logic [28:0] KS_KP_DEC    = 29'h0FFAE;
    localparam logic [28:0] KS_KP_DIV    = 29'h0FFAF;
    localparam logic [28:0] KS_KP_0      = 29'h0FFB0;
    localparam logic [28:0] KS_KP_9      = 29'h0FFB9;
    localparam logic [28:0] KS_F1        = 29'h0FFBE;
    localparam logic [28:0] KS_F2        = 29'h0FFBF;
    localparam logic [28:0] KS_F3        = 29'h0FFC0;
    localparam logic [28:0] KS_F4        = 29'h0FFC1;
    localparam logic [28:0] KS_F5        = 29'h0FFC2;
    localparam logic [28:0] KS_F6        = 29'h0FFC3;
    localparam logic [28:0] KS_F7        = 29'h0FFC4;
    localparam logic [28:0] KS_F8        = 29'h0FFC5;
    localparam logic [28:0] KS_F9        = 29'h0FFC6;
    localparam logic [28:0] KS_F10       = 29'h0FFC7;
    localparam logic [28:0] KS_F11       = 29'h0FFC8;
    localparam logic [28:0] KS_F12       = 29'h0FFC9;
    localparam logic [28:0] KS_SHIFT_L   = 29'h0FFE1;
    localparam logic [28:0] KS_SHIFT_R   = 29'h0FFE2;
    localparam logic [28:0] KS_CTRL_L    = 29'h0FFE3;
    localparam logic [28:0] KS_CTRL_R    = 29'h0FFE4;
    localparam logic [28:0] KS_META_L    = 29'h0FFE7;
    localparam logic [28:0] KS_META_R    = 29'h0FFE8;
    localparam logic [28:0] KS_ALT_L     = 29'h0FFE9;
    localparam logic [28:0] KS_ALT_R     = 29'h0FFEA;
    localparam logic [28:0] KS_SUPER_L   = 29'h0FFEB;
    localparam logic [28:0] KS_SUPER_R   = 29'h0FFEC;
    localparam logic [28:0] KS_HYPER_L   = 29'h0FFED;
    localparam logic [28:0] KS_HYPER_R   = 29'h0FFEE;

    // Append one byte
    function automatic kste_seq_t put(input kste_seq_t s, input logic [7:0] b);
        kste_seq_t r;
        r = s;
        r.bytes[r.len] = b;
        r.len = r.len + 3'd1;
        return r;
    endfunction

    // Append a decimal number of at most two digits (num <= 24)
    function automatic kste_seq_t put_dec(input kste_seq_t s, input logic [4:0] num);
        kste_seq_t  r;
        logic [4:0] ones;
        r = s;
        if (num >= 5'd20)
        begin
            r = put(r, 8'h32);
            ones = num - 5'd20;
        end
        else if (num >= 5'd10)
        begin
            r = put(r, 8'h31);
            ones = num - 5'd10;
        end
        else
        begin
            ones = num;
        end
        r = put(r, CH_ZERO + {3'b000, ones});
        return r;
    endfunction

    // ESC [ num ; m fin with modifiers, else ESC intro [num] fin
    function automatic kste_seq_t key_seq(input logic [7:0] intro, input logic [4:0] num,
                                          input logic [2:0] m, input logic [7:0] fin);
        kste_seq_t r;
        r = '0;
        r = put(r, CH_ESC);
        if (m != 3'd0)
        begin
            r = put(r, CH_LBRACK);
            r = put_dec(r, num);
            r = put(r, CH_SEMI);
            r = put(r, CH_ZERO + {5'b00000, m} + 8'd1);
        end
        else
        begin
            r = put(r, intro);
            if (fin == CH_TILDE)
            begin
                r = put_dec(r, num);
            end
        end
        r = put(r, fin);
        return r;
    endfunction

    logic [28:0] ks;
    logic [2:0]  m;
    logic [7:0]  intro;
    logic        arrow;
    logic [7:0]  arrow_fin;
    logic [28:0] pk;
    logic [28:0] cp_wide;
    logic [20:0] cp;
    logic        utf;
    logic        plain_noconv;
    kste_seq_t   plain_seq;
    kste_seq_t   main_seq;
    logic        main_noconv;

    // Modifier number bits: control, alt, shift
    assign m = {|(item.modifier_state & cfg.control_mask),
                |(item.modifier_state & cfg.alt_mask),
                |(item.modifier_state & cfg.shift_mask)};

    assign intro = item.cursor_app_mode ? CH_SS3 : CH_LBRACK;

    // Keypad folding
    always_comb
    begin
        unique case (item.key_symbol)
            KS_KP_SPACE: ks = 29'h20;
            KS_KP_TAB:   ks = KS_TAB;
            KS_KP_ENTER: ks = KS_RETURN;
            KS_KP_LEFT:  ks = KS_LEFT;
            KS_KP_UP:    ks = KS_UP;
            KS_KP_RIGHT: ks = KS_RIGHT;
            KS_KP_DOWN:  ks = KS_DOWN;
            KS_KP_EQUAL: ks = 29'h3D;
            KS_KP_MUL:   ks = 29'h2A;
            KS_KP_ADD:   ks = 29'h2B;
            KS_KP_SEP:   ks = 29'h2E;
            KS_KP_SUB:   ks = 29'h2D;
            KS_KP_DEC:   ks = 29'h2E;
            KS_KP_DIV:   ks = 29'h2F;
            default:
            begin
                if (item.key_symbol >= KS_KP_0 && item.key_symbol <= KS_KP_9)
                begin
                    ks = 29'h30 + {25'd0, item.key_symbol[3:0]};
                end
                else
                begin
                    ks = item.key_symbol;
                end
            end
        endcase
    end

    // Cursor keys honor the cursor mode
    always_comb
    begin
        arrow = 1'b1;
        unique case (ks)
            KS_LEFT:  arrow_fin = 8'h44;
            KS_RIGHT: arrow_fin = 8'h43;
            KS_UP:    arrow_fin = 8'h41;
            KS_DOWN:  arrow_fin = 8'h42;
            KS_HOME:  arrow_fin = 8'h48;
            KS_END:   arrow_fin = 8'h46;
            default:
            begin
                arrow = 1'b0;
                arrow_fin = 8'h00;
            end
        endcase
    end

    // Plain keys: control folding, alt high bit, single byte or UTF-8; cursor keys get their escape sequence
    always_comb
    begin
        pk = ks;
        utf = 1'b1;
        plain_noconv = 1'b0;
        cp = '0;
        cp_wide = '0;
        plain_seq = '0;
        if (m[2])
        begin
            if (pk >= 29'h33 && pk <= 29'h37)
            begin
                pk = {24'd0, pk[4:0]} + 29'd8;
            end
            if (!((pk >= 29'h21 && pk <= 29'h2F) || (pk >= 29'h38 && pk <= 29'h3F) ||
                  (pk >= 29'h30 && pk <= 29'h32)))
            begin
                pk = pk & 29'h1F;
            end
            else if (pk == 29'h32)
            begin
                pk = 29'h00;
            end
            else if (pk == 29'h2F)
            begin
                pk = 29'h1F;
            end
            else if (pk == 29'h38 || pk == 29'h3F)
            begin
                pk = 29'h7F;
            end
        end
        if (m[1])
        begin
            pk = pk | 29'h80;
            utf = 1'b0;
        end

        if (arrow)
        begin
            plain_seq = key_seq(intro, 5'd1, m, arrow_fin);
        end
        else if (pk < 29'h80 || (!utf && pk < 29'h100))
        begin
            plain_seq = put(plain_seq, pk[7:0]);
        end
        else
        begin
            // Latin-1 passes as is, direct Unicode drops its marker bit
            if (pk >= 29'hA0 && pk <= 29'hFF)
            begin
                cp = pk[20:0];
            end
            else if (pk >= 29'h0100_0100 && pk <= 29'h0110_FFFF)
            begin
                cp_wide = pk - 29'h0100_0000;
                cp = cp_wide[20:0];
            end
            else
            begin
                plain_noconv = 1'b1;
            end
            if (cp >= 21'h0D800 && cp <= 21'h0DFFF)
            begin
                plain_noconv = 1'b1;
            end
            if (!plain_noconv)
            begin
                if (cp < 21'h800)
                begin
                    plain_seq = put(plain_seq, 8'hC0 | {3'b000, cp[10:6]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[5:0]});
                end
                else if (cp < 21'h10000)
                begin
                    plain_seq = put(plain_seq, 8'hE0 | {4'h0, cp[15:12]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[11:6]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[5:0]});
                end
                else
                begin
                    plain_seq = put(plain_seq, 8'hF0 | {5'b00000, cp[20:18]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[17:12]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[11:6]});
                    plain_seq = put(plain_seq, 8'h80 | {2'b00, cp[5:0]});
                end
            end
        end
    end

    // Special keys
    always_comb
    begin
        main_seq = '0;
        main_noconv = 1'b0;
        unique case (ks)
            KS_BACKSPACE:
            begin
                if (m[1])
                begin
                    main_seq = put(main_seq, CH_ESC);
                end
                main_seq = put(main_seq, 8'h7F);
            end
            KS_TAB, KS_LINEFEED, KS_CLEAR, KS_PAUSE, KS_SCROLL, KS_SYSREQ, KS_ESCAPE:
            begin
                main_seq = put(main_seq, {1'b0, ks[6:0]});
            end
            KS_RETURN:
            begin
                main_seq = put(main_seq, 8'h0D);
                if (item.newline_mode)
                begin
                    main_seq = put(main_seq, 8'h0A);
                end
            end
            KS_SHIFT_L, KS_SHIFT_R, KS_CTRL_L, KS_CTRL_R, KS_META_L, KS_META_R,
            KS_ALT_L, KS_ALT_R, KS_SUPER_L, KS_SUPER_R, KS_HYPER_L, KS_HYPER_R:
            begin
                main_seq = '0;
            end
            KS_INSERT: main_seq = key_seq(CH_LBRACK, 5'd2, m, CH_TILDE);
            KS_DELETE: main_seq = key_seq(CH_LBRACK, 5'd3, m, CH_TILDE);
            KS_PRIOR:  main_seq = key_seq(CH_LBRACK, 5'd5, m, CH_TILDE);
            KS_NEXT:   main_seq = key_seq(CH_LBRACK, 5'd6, m, CH_TILDE);
            KS_F1:     main_seq = key_seq(CH_SS3, 5'd1, m, 8'h50);
            KS_F2:     main_seq = key_seq(CH_SS3, 5'd1, m, 8'h51);
            KS_F3:     main_seq = key_seq(CH_SS3, 5'd1, m, 8'h52);
            KS_F4:     main_seq = key_seq(CH_SS3, 5'd1, m, 8'h53);
            KS_F5:     main_seq = key_seq(CH_LBRACK, 5'd15, m, CH_TILDE);
            KS_F6:     main_seq = key_seq(CH_LBRACK, 5'd17, m, CH_TILDE);
            KS_F7:     main_seq = key_seq(CH_LBRACK, 5'd18, m, CH_TILDE);
            KS_F8:     main_seq = key_seq(CH_LBRACK, 5'd19, m, CH_TILDE);
            KS_F9:     main_seq = key_seq(CH_LBRACK, 5'd20, m, CH_TILDE);
            KS_F10:    main_seq = key_seq(CH_LBRACK, 5'd21, m, CH_TILDE);
            // F11 sends 23, as xterm does
            KS_F11:    main_seq = key_seq(CH_LBRACK, 5'd23, m, CH_TILDE);
            KS_F12:    main_seq = key_seq(CH_LBRACK, 5'd24, m, CH_TILDE);
            default:
            begin
                main_seq = plain_seq;
                main_noconv = plain_noconv;
            end
        endcase
    end

    // Final status
    always_comb
    begin
        seq = main_seq;
        if (main_noconv)
        begin
            seq.status = STATUS_NOCONV;
        end
        else if (main_seq.len == '0)
        begin
            seq.status = STATUS_NONE;
        end
        else
        begin
            seq.status = STATUS_BYTE;
        end
    end

endmodule

@@ rtl/core/keysym_to_terminal_escape_encoder.sv @@
// Top level: config registers, input register, encoder and byte serializer.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------
//  command  | start in, busy out            | cmd (key_item_t)
//  result   | result_valid out (strobe)     | result (key_result_t)
//  config   | cfg_write in                  | cfg_index, cfg_data
//
// A command is taken into the input register, encoded in one pass and loaded
// into the output shift register, which sends one byte per cycle; a key gives 1 to 7
// results, set by the length of its sequence. The next command is
// taken while the current sequence goes out; busy rises only when the input
// register is full and the serializer has more than its last byte to send.
// Reset clears the valid flags and sets the masks to shift 1, alt 8, control 4.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module keysym_to_terminal_escape_encoder
    import kste_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  key_item_t   cmd,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        result_valid,
    output key_result_t result
);

    kste_cfg_t                cfg_reg;
    key_item_t                item_reg;
    logic                     item_valid_reg;
    logic                     item_valid_next;
    logic [SEQ_MAX-1:0][7:0]  buf_reg;
    logic [SEQ_MAX-1:0][7:0]  buf_next;
    logic [LEN_W-1:0]         rem_reg;
    logic [LEN_W-1:0]         rem_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    kste_seq_t                enc_seq;
    logic                     accept;
    logic                     load;
    logic                     ser_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_mask   <= 8'd1;
            cfg_reg.alt_mask     <= 8'd8;
            cfg_reg.control_mask <= 8'd4;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SHIFT_MASK:   cfg_reg.shift_mask   <= cfg_data;
                CFG_ALT_MASK:     cfg_reg.alt_mask     <= cfg_data;
                CFG_CONTROL_MASK: cfg_reg.control_mask <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake control
    assign ser_free = !out_valid_reg || (rem_reg == 3'd1);
    assign load     = item_valid_reg && ser_free;
    assign busy     = item_valid_reg && !ser_free;
    assign accept   = start && !busy;

    assign item_valid_next = accept ? 1'b1 : (load ? 1'b0 : item_valid_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
    end

    kste_encoder u_encoder (
        .item (item_reg),
        .cfg  (cfg_reg),
        .seq  (enc_seq)
    );

    // Serializer next state: load a new sequence or shift out one byte
    always_comb
    begin
        buf_next       = buf_reg;
        rem_next       = rem_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = enc_seq.status;
            if (enc_seq.status == STATUS_BYTE)
            begin
                buf_next = enc_seq.bytes;
                rem_next = enc_seq.len;
            end
            else
            begin
                buf_next = '0;
                rem_next = 3'd1;
            end
        end
        else if (out_valid_reg)
        begin
            if (rem_reg == 3'd1)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                buf_next = {8'h00, buf_reg[SEQ_MAX-1:1]};
                rem_next = rem_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        status_reg <= status_next;
    end

    // Result port
    assign result_valid    = out_valid_reg;
    assign result.out_byte = buf_reg[0];
    assign result.last     = (rem_reg == 3'd1);
    assign result.status   = status_reg;

endmodule

@@ sim/keysym_to_terminal_escape_encoder_tb.sv @@
// Testbench for the keysym to terminal escape encoder: random and directed keys, byte by byte.
module keysym_to_terminal_escape_encoder_tb;
    import kste_pkg::*;

    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned RANDOM_PER_PHASE = 48;

    // Register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Modifier bits as the reset masks see them
    localparam logic [7:0] MOD_NONE    = 8'h00;
    localparam logic [7:0] MOD_SHIFT   = 8'h01;
    localparam logic [7:0] MOD_CONTROL = 8'h04;
    localparam logic [7:0] MOD_ALT     = 8'h08;

    // Byte values
    localparam logic [7:0] B_LF  = 8'h0A;
    localparam logic [7:0] B_CR  = 8'h0D;
    localparam logic [7:0] B_ESC = 8'h1B;
    localparam logic [7:0] B_DEL = 8'h7F;

    // Keysyms
    localparam logic [28:0] KS_BACKSPACE   = 29'hFF08;
    localparam logic [28:0] KS_TAB         = 29'hFF09;
    localparam logic [28:0] KS_LINEFEED    = 29'hFF0A;
    localparam logic [28:0] KS_CLEAR       = 29'hFF0B;
    localparam logic [28:0] KS_RETURN      = 29'hFF0D;
    localparam logic [28:0] KS_PAUSE       = 29'hFF13;
    localparam logic [28:0] KS_SCROLL_LOCK = 29'hFF14;
    localparam logic [28:0] KS_SYS_REQ     = 29'hFF15;
    localparam logic [28:0] KS_ESCAPE      = 29'hFF1B;
    localparam logic [28:0] KS_HOME        = 29'hFF50;
    localparam logic [28:0] KS_LEFT        = 29'hFF51;
    localparam logic [28:0] KS_UP          = 29'hFF52;
    localparam logic [28:0] KS_RIGHT       = 29'hFF53;
    localparam logic [28:0] KS_DOWN        = 29'hFF54;
    localparam logic [28:0] KS_PRIOR       = 29'hFF55;
    localparam logic [28:0] KS_NEXT        = 29'hFF56;
    localparam logic [28:0] KS_END         = 29'hFF57;
    localparam logic [28:0] KS_INSERT      = 29'hFF63;
    localparam logic [28:0] KS_DELETE      = 29'hFFFF;
    localparam logic [28:0] KS_F1          = 29'hFFBE;
    localparam logic [28:0] KS_F2          = 29'hFFBF;
    localparam logic [28:0] KS_F3          = 29'hFFC0;
    localparam logic [28:0] KS_F4          = 29'hFFC1;
    localparam logic [28:0] KS_F5          = 29'hFFC2;
    localparam logic [28:0] KS_F6          = 29'hFFC3;
    localparam logic [28:0] KS_F7          = 29'hFFC4;
    localparam logic [28:0] KS_F8          = 29'hFFC5;
    localparam logic [28:0] KS_F9          = 29'hFFC6;
    localparam logic [28:0] KS_F10         = 29'hFFC7;
    localparam logic [28:0] KS_F11         = 29'hFFC8;
    localparam logic [28:0] KS_F12         = 29'hFFC9;
    localparam logic [28:0] KS_F13         = 29'hFFCA;
    localparam logic [28:0] KS_KP_SPACE    = 29'hFF80;
    localparam logic [28:0] KS_KP_TAB      = 29'hFF89;
    localparam logic [28:0] KS_KP_ENTER    = 29'hFF8D;
    localparam logic [28:0] KS_KP_F1       = 29'hFF91;
    localparam logic [28:0] KS_KP_HOME     = 29'hFF95;
    localparam logic [28:0] KS_KP_LEFT     = 29'hFF96;
    localparam logic [28:0] KS_KP_UP       = 29'hFF97;
    localparam logic [28:0] KS_KP_RIGHT    = 29'hFF98;
    localparam logic [28:0] KS_KP_DOWN     = 29'hFF99;
    localparam logic [28:0] KS_KP_MULTIPLY = 29'hFFAA;
    localparam logic [28:0] KS_KP_ADD      = 29'hFFAB;
    localparam logic [28:0] KS_KP_SEP      = 29'hFFAC;
    localparam logic [28:0] KS_KP_SUBTRACT = 29'hFFAD;
    localparam logic [28:0] KS_KP_DECIMAL  = 29'hFFAE;
    localparam logic [28:0] KS_KP_DIVIDE   = 29'hFFAF;
    localparam logic [28:0] KS_KP_0        = 29'hFFB0;
    localparam logic [28:0] KS_KP_5        = 29'hFFB5;
    localparam logic [28:0] KS_KP_9        = 29'hFFB9;
    localparam logic [28:0] KS_KP_EQUAL    = 29'hFFBD;
    localparam logic [28:0] KS_SHIFT_L     = 29'hFFE1;
    localparam logic [28:0] KS_SHIFT_R     = 29'hFFE2;
    localparam logic [28:0] KS_CONTROL_L   = 29'hFFE3;
    localparam logic [28:0] KS_CONTROL_R   = 29'hFFE4;
    localparam logic [28:0] KS_META_L      = 29'hFFE7;
    localparam logic [28:0] KS_META_R      = 29'hFFE8;
    localparam logic [28:0] KS_ALT_L       = 29'hFFE9;
    localparam logic [28:0] KS_ALT_R       = 29'hFFEA;
    localparam logic [28:0] KS_SUPER_L     = 29'hFFEB;
    localparam logic [28:0] KS_SUPER_R     = 29'hFFEC;
    localparam logic [28:0] KS_HYPER_L     = 29'hFFED;
    localparam logic [28:0] KS_HYPER_R     = 29'hFFEE;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    key_item_t   cmd = '0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_SHIFT_MASK;
    logic [7:0]  cfg_data = 8'h00;
    logic        result_valid;
    key_result_t result;

    // Local copy of the modifier masks
    logic [7:0] shift_msk = 8'h01;
    logic [7:0] alt_msk   = 8'h08;
    logic [7:0] ctrl_msk  = 8'h04;

    key_item_t   keys_to_send[$];
    key_result_t key_bytes_due[$];
    logic [7:0]  seq_q[$];
    logic [28:0] special_keys[$];

    int error_count   = 0;
    int keys_sent     = 0;
    int results_seen  = 0;
    int noconv_seen   = 0;
    int none_seen     = 0;
    int mask_settings = 1;
    int idle_cycles   = 0;
    int gap_left      = 0;
    int quiet_left    = 0;

    keysym_to_terminal_escape_encoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    always #2 clk = ~clk;

    // Sequence builder; anything past the longest sequence is dropped
    function automatic void emit_byte(logic [7:0] b);
        if (seq_q.size() < SEQ_MAX)
            seq_q.push_back(b);
    endfunction

    function automatic void emit_decimal(int unsigned n);
        if (n >= 10)
            emit_byte("0" + 8'((n / 10) % 10));
        emit_byte("0" + 8'(n % 10));
    endfunction

    // ESC intro [num] fin, or ESC [ num ; mod fin when a modifier is held
    function automatic void emit_key_seq(logic [7:0] intro, int unsigned num,
                                         logic [7:0] mods, logic [7:0] fin);
        int unsigned m;
        m = 0;
        if ((mods & shift_msk) != 8'h00) m |= 1;
        if ((mods & alt_msk) != 8'h00)   m |= 2;
        if ((mods & ctrl_msk) != 8'h00)  m |= 4;
        emit_byte(B_ESC);
        if (m != 0)
        begin
            emit_byte("[");
            emit_decimal(num);
            emit_byte(";");
            emit_decimal(m + 1);
        end
        else
        begin
            emit_byte(intro);
            if (fin == "~")
                emit_decimal(num);
        end
        emit_byte(fin);
    endfunction

    // Work out the results of one key and queue them
    function automatic void encode_key(key_item_t k);
        logic [31:0] ks;
        logic [31:0] cp;
        logic [7:0]  mods;
        logic [7:0]  intro;
        logic        utf_ok;
        status_t     st;
        key_result_t r;
        seq_q.delete();
        st = STATUS_BYTE;
        cp = '0;
        ks = {3'b000, k.key_symbol};
        mods = k.modifier_state;
        intro = k.cursor_app_mode ? "O" : "[";

        // Keypad keys fold to their plain keysyms first
        case (ks)
            KS_KP_SPACE:    ks = 32'h20;
            KS_KP_TAB:      ks = KS_TAB;
            KS_KP_ENTER:    ks = KS_RETURN;
            KS_KP_LEFT:     ks = KS_LEFT;
            KS_KP_UP:       ks = KS_UP;
            KS_KP_RIGHT:    ks = KS_RIGHT;
            KS_KP_DOWN:     ks = KS_DOWN;
            KS_KP_EQUAL:    ks = "=";
            KS_KP_MULTIPLY: ks = "*";
            KS_KP_ADD:      ks = "+";
            KS_KP_SEP, KS_KP_DECIMAL: ks = ".";
            KS_KP_SUBTRACT: ks = "-";
            KS_KP_DIVIDE:   ks = "/";
            default:
                if (ks >= KS_KP_0 && ks <= KS_KP_9)
                    ks = ks - KS_KP_0 + "0";
        endcase

        case (ks)
            KS_BACKSPACE:
            begin
                if ((mods & alt_msk) != 8'h00)
                    emit_byte(B_ESC);
                emit_byte(B_DEL);
            end
            KS_TAB, KS_LINEFEED, KS_CLEAR, KS_PAUSE, KS_SCROLL_LOCK, KS_SYS_REQ, KS_ESCAPE:
                emit_byte({1'b0, ks[6:0]});
            KS_RETURN:
            begin
                emit_byte(B_CR);
                if (k.newline_mode)
                    emit_byte(B_LF);
            end
            // modifier keys send nothing
            KS_SHIFT_L, KS_SHIFT_R, KS_CONTROL_L, KS_CONTROL_R, KS_META_L, KS_META_R,
            KS_ALT_L, KS_ALT_R, KS_SUPER_L, KS_SUPER_R, KS_HYPER_L, KS_HYPER_R: ;
            KS_INSERT: emit_key_seq("[", 2, mods, "~");
            KS_DELETE: emit_key_seq("[", 3, mods, "~");
            KS_PRIOR:  emit_key_seq("[", 5, mods, "~");
            KS_NEXT:   emit_key_seq("[", 6, mods, "~");
            KS_F1:     emit_key_seq("O", 1, mods, "P");
            KS_F2:     emit_key_seq("O", 1, mods, "Q");
            KS_F3:     emit_key_seq("O", 1, mods, "R");
            KS_F4:     emit_key_seq("O", 1, mods, "S");
            KS_F5:     emit_key_seq("[", 15, mods, "~");
            KS_F6:     emit_key_seq("[", 17, mods, "~");
            KS_F7:     emit_key_seq("[", 18, mods, "~");
            KS_F8:     emit_key_seq("[", 19, mods, "~");
            KS_F9:     emit_key_seq("[", 20, mods, "~");
            KS_F10:    emit_key_seq("[", 21, mods, "~");
            KS_F11:    emit_key_seq("[", 23, mods, "~");
            KS_F12:    emit_key_seq("[", 24, mods, "~");
            KS_LEFT:   emit_key_seq(intro, 1, mods, "D");
            KS_RIGHT:  emit_key_seq(intro, 1, mods, "C");
            KS_UP:     emit_key_seq(intro, 1, mods, "A");
            KS_DOWN:   emit_key_seq(intro, 1, mods, "B");
            KS_HOME:   emit_key_seq(intro, 1, mods, "H");
            KS_END:    emit_key_seq(intro, 1, mods, "F");
            default:
            begin
                // control folding
                if ((mods & ctrl_msk) != 8'h00)
                begin
                    if (ks >= "3" && ks <= "7")
                        ks = (ks & 32'h1F) + 8;
                    if (!((ks >= "!" && ks <= "/") || (ks >= "8" && ks <= "?") ||
                          (ks >= "0" && ks <= "2")))
                        ks &= 32'h1F;
                    else if (ks == "2")
                        ks = 32'h00;
                    else if (ks == "/")
                        ks = 32'h1F;
                    else if (ks == "8" || ks == "?")
                        ks = 32'h7F;
                end
                utf_ok = 1'b1;
                if ((mods & alt_msk) != 8'h00)
                begin
                    ks |= 32'h80;
                    utf_ok = 1'b0;
                end
                if (ks < 32'h80 || (!utf_ok && ks < 32'h100))
                begin
                    emit_byte(ks[7:0]);
                end
                else
                begin
                    if (ks >= 32'hA0 && ks <= 32'hFF)
                        cp = ks;
                    else if (ks >= 32'h0100_0100 && ks <= 32'h0110_FFFF)
                        cp = ks - 32'h0100_0000;
                    else
                        st = STATUS_NOCONV;
                    if (st == STATUS_BYTE && cp >= 32'hD800 && cp <= 32'hDFFF)
                        st = STATUS_NOCONV;
                    // UTF-8, two to four bytes here
                    if (st == STATUS_BYTE)
                    begin
                        if (cp < 32'h800)
                        begin
                            emit_byte({3'b110, cp[10:6]});
                            emit_byte({2'b10, cp[5:0]});
                        end
                        else if (cp < 32'h10000)
                        begin
                            emit_byte({4'b1110, cp[15:12]});
                            emit_byte({2'b10, cp[11:6]});
                            emit_byte({2'b10, cp[5:0]});
                        end
                        else
                        begin
                            emit_byte({5'b11110, cp[20:18]});
                            emit_byte({2'b10, cp[17:12]});
                            emit_byte({2'b10, cp[11:6]});
                            emit_byte({2'b10, cp[5:0]});
                        end
                    end
                end
            end
        endcase

        if (st != STATUS_BYTE || seq_q.size() == 0)
        begin
            r.out_byte = 8'h00;
            r.last = 1'b1;
            if (st != STATUS_BYTE)
                r.status = STATUS_NOCONV;
            else
                r.status = STATUS_NONE;
            key_bytes_due.push_back(r);
        end
        else
        begin
            foreach (seq_q[i])
            begin
                r.out_byte = seq_q[i];
                r.last = (i == seq_q.size() - 1);
                r.status = STATUS_BYTE;
                key_bytes_due.push_back(r);
            end
        end
    endfunction

    function automatic void queue_key(logic [28:0] ks, logic [7:0] mods, logic app, logic nl);
        key_item_t k;
        k.key_symbol = ks;
        k.modifier_state = mods;
        k.cursor_app_mode = app;
        k.newline_mode = nl;
        keys_to_send.push_back(k);
    endfunction

    // Random key weighted toward the interesting keysym classes
    function automatic void queue_random_key();
        logic [28:0] ks;
        logic [7:0]  mods;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            ks = special_keys[$urandom_range(0, special_keys.size() - 1)];
        else if (pick < 52)
            ks = 29'($urandom_range(32'h20, 32'h7E));
        else if (pick < 58)
            ks = 29'($urandom_range(32'h00, 32'h1F));
        else if (pick < 68)
            ks = 29'($urandom_range(32'h80, 32'hFF));
        else if (pick < 80)
        begin
            case ($urandom_range(0, 3))
                0: ks = 29'($urandom_range(32'h0100_00F0, 32'h0100_0110));
                1: ks = 29'($urandom_range(32'h0100_D7F0, 32'h0100_E010));
                2: ks = 29'($urandom_range(32'h0110_FFF0, 32'h0111_0010));
                default: ks = 29'($urandom_range(32'h0100_0000, 32'h0110_FFFF));
            endcase
        end
        else if (pick < 88)
            ks = 29'($urandom_range(32'hFF00, 32'hFFFF));
        else
            ks = 29'($urandom);
        mods = ($urandom_range(0, 3) == 0) ? MOD_NONE : 8'($urandom);
        queue_key(ks, mods, 1'($urandom), 1'($urandom));
    endfunction

    // Block is idle once nothing is waiting to go in or come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (keys_to_send.size() != 0 || start || key_bytes_due.size() != 0);
    endtask

    task automatic apply_masks(logic [7:0] s, logic [7:0] a, logic [7:0] c);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SHIFT_MASK;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= CFG_ALT_MASK;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= CFG_CONTROL_MASK;
        cfg_data  <= c;
        // a write to the empty index must change nothing
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        shift_msk = s;
        alt_msk = a;
        ctrl_msk = c;
        mask_settings++;
    endtask

    // Driver: one transaction per start/!busy edge, random gaps between keys
    always @(posedge clk)
    begin : key_driver
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                encode_key(cmd);
                keys_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (keys_to_send.size() != 0)
                begin
                    cmd <= keys_to_send.pop_front();
                    start <= 1'b1;
                    if (quiet_left > 0)
                    begin
                        quiet_left <= quiet_left - 1;
                        gap_left <= 0;
                    end
                    else
                    begin
                        gap_left <= $urandom_range(0, 16);
                        if ($urandom_range(0, 11) == 0)
                            quiet_left <= $urandom_range(4, 24);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is checked against the oldest expected byte
    always @(posedge clk)
    begin : result_monitor
        key_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (result.status == STATUS_NOCONV) noconv_seen++;
            if (result.status == STATUS_NONE)   none_seen++;
            if (key_bytes_due.size() == 0)
            begin
                error_count++;
                $display("%0t: expected no result, got byte %02h last %0b status %0d",
                         $time, result.out_byte, result.last, result.status);
            end
            else
            begin
                want = key_bytes_due.pop_front();
                if (result.out_byte !== want.out_byte || result.last !== want.last ||
                    result.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: expected byte %02h last %0b status %0d, %s",
                             $time, want.out_byte, want.last, want.status,
                             $sformatf("got byte %02h last %0b status %0d",
                                       result.out_byte, result.last, result.status));
                end
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || result_valid)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles < STALL_LIMIT)
        begin
            idle_cycles <= idle_cycles + 1;
        end
        else
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        special_keys = '{KS_BACKSPACE, KS_TAB, KS_LINEFEED, KS_CLEAR, KS_RETURN, KS_PAUSE,
                         KS_SCROLL_LOCK, KS_SYS_REQ, KS_ESCAPE, KS_HOME, KS_LEFT, KS_UP,
                         KS_RIGHT, KS_DOWN, KS_PRIOR, KS_NEXT, KS_END, KS_INSERT, KS_DELETE,
                         KS_F1, KS_F2, KS_F3, KS_F4, KS_F5, KS_F6, KS_F7, KS_F8, KS_F9,
                         KS_F10, KS_F11, KS_F12, KS_F13, KS_KP_SPACE, KS_KP_TAB,
                         KS_KP_ENTER, KS_KP_F1, KS_KP_HOME, KS_KP_LEFT, KS_KP_UP,
                         KS_KP_RIGHT, KS_KP_DOWN, KS_KP_MULTIPLY, KS_KP_ADD, KS_KP_SEP,
                         KS_KP_SUBTRACT, KS_KP_DECIMAL, KS_KP_DIVIDE, KS_KP_0, KS_KP_5,
                         KS_KP_9, KS_KP_EQUAL, KS_SHIFT_L, KS_SHIFT_R, KS_CONTROL_L,
                         KS_CONTROL_R, KS_META_L, KS_META_R, KS_ALT_L, KS_ALT_R,
                         KS_SUPER_L, KS_SUPER_R, KS_HYPER_L, KS_HYPER_R};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed keys, then random ones, under the reset masks
        queue_key(29'h0, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h1FFF_FFFF, 8'hFF, 1'b1, 1'b1);
        queue_key(KS_RETURN, MOD_NONE, 1'b0, 1'b1);
        queue_key(KS_RETURN, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_BACKSPACE, MOD_ALT, 1'b0, 1'b0);
        queue_key(KS_ESCAPE, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_LEFT, MOD_NONE, 1'b1, 1'b0);
        queue_key(KS_UP, MOD_SHIFT | MOD_ALT | MOD_CONTROL, 1'b0, 1'b0);
        queue_key(KS_F11, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_F12, MOD_SHIFT | MOD_ALT | MOD_CONTROL, 1'b0, 1'b0);
        queue_key(KS_F1, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_PRIOR, MOD_SHIFT, 1'b0, 1'b0);
        queue_key(KS_SHIFT_L, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h0E9, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h0101_F600, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h0100_D800, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h0110_FFFF, MOD_NONE, 1'b0, 1'b0);
        queue_key(29'h0111_0000, MOD_NONE, 1'b0, 1'b0);
        queue_key("3", MOD_CONTROL, 1'b0, 1'b0);
        queue_key("2", MOD_CONTROL, 1'b0, 1'b0);
        queue_key("/", MOD_CONTROL, 1'b0, 1'b0);
        queue_key("?", MOD_CONTROL, 1'b0, 1'b0);
        queue_key("a", MOD_CONTROL | MOD_ALT, 1'b0, 1'b0);
        queue_key(KS_KP_5, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_KP_ENTER, MOD_NONE, 1'b0, 1'b1);
        queue_key(KS_KP_UP, MOD_NONE, 1'b1, 1'b0);
        queue_key(KS_KP_F1, MOD_NONE, 1'b0, 1'b0);
        queue_key(KS_DELETE, MOD_CONTROL, 1'b0, 1'b0);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_key();
        wait_drained();

        // Random keys under further mask settings, extremes first
        for (int phase = 1; phase <= 5; phase++)
        begin
            case (phase)
                1: apply_masks(8'h00, 8'h00, 8'h00);
                2: apply_masks(8'hFF, 8'hFF, 8'hFF);
                3: apply_masks(8'h02, 8'h10, 8'h80);
                default: apply_masks(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            @(negedge clk);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                queue_random_key();
            wait_drained();
        end

        repeat (3 * SEQ_MAX) @(posedge clk);
        if (key_bytes_due.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, key_bytes_due.size());
        end
        $display("Sent %0d keys under %0d mask settings; checked %0d results.",
                 keys_sent, mask_settings, results_seen);
        $display("Of those, %0d were empty and %0d unconvertible.", none_seen, noconv_seen);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
